>>> rtl/core/mm64_pkg.sv
// Package for the murmur64 stream hash: register indexes, reset values, sequencer states.
package mm64_pkg;

  // Bytes in one message word
  localparam int unsigned BLOCK_BYTES = 8;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HASH_SEED      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIX_MULTIPLIER = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIX_SHIFT      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FOLD_CASE      = 3'd3;

  // Register reset values
  localparam logic [63:0] MIX_MULT_RESET  = 64'hC6A4_A793_5BD1_E995;
  localparam logic [5:0]  MIX_SHIFT_RESET = 6'd47;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,     // waiting for a beat
    ST_START,    // beat captured, pick first operation
    ST_LEN_MUL,  // total_length * m
    ST_K1_MUL,   // word * m
    ST_K2_MUL,   // (k ^ k >> r) * m
    ST_ACC_MUL,  // (acc ^ k) * m
    ST_FINAL     // load result register
  } mm64_state_e;

endpackage

>>> rtl/core/mm64_if.sv
// Stream channel interfaces for the murmur64 stream hash: message words in, hashes out.
interface mm64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        first_word;
  logic        last_word;
  logic [31:0] total_length;

  modport source (
    output valid, data_word, byte_count, first_word, last_word, total_length,
    input  ready
  );
  modport sink (
    input  valid, data_word, byte_count, first_word, last_word, total_length,
    output ready
  );
endinterface

interface mm64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );
  modport sink (
    input  valid, hash_value,
    output ready
  );
endinterface

>>> rtl/core/murmur64_stream_hash.sv
// Top level of the murmur64 stream hash: sequencer around one shared 32x32 multiplier.
//
// Words of a message arrive one beat at a time on in_i; after a beat marked
// last_word the hash appears on out_o. Every 64-bit product is built from three
// 32x32 partial products on a single shared multiplier. A beat holds ready low
// from its capture until the sequencer returns to idle: with first_word the
// length is multiplied first, a full word takes three multiplies, a partial word
// one and an empty one none, and with last_word the result register is loaded
// (plus any wait for the output register to free up). The next beat is taken in
// the idle state that follows. The result register on out_o is separate, so the
// next word is accepted while a hash still waits to be taken. Configuration is
// written through cfg_we_i while idle; the user must ensure this, the block does not.
module murmur64_stream_hash
  import mm64_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mm64_in_if.sink             in_i,
  mm64_out_if.source          out_o
);

  // Configuration registers
  logic [63:0] seed_q, mult_q;
  logic [5:0]  shift_q;
  logic        fold_q;

  // Sequencer and datapath registers
  mm64_state_e state_q, state_d, disp_state;
  logic [1:0]  ph_q, ph_d;
  logic [63:0] a_q, a_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] pp_q, pp_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] word_q, word_d;
  logic [3:0]  count_q, count_d;
  logic        first_q, last_q;
  logic [31:0] len_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;

  logic        accept, mul_state, mul_done, out_free;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_full, acc_base, masked, final_val;

  // Lowercase ASCII A-Z in each byte lane
  function automatic logic [63:0] lower_word(input logic [63:0] w);
    logic [63:0] r;
    logic [7:0]  b;
    r = w;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      b = w[8*i +: 8];
      if (b >= 8'h41 && b <= 8'h5A) begin
        r[8*i +: 8] = b | 8'h20;
      end
    end
    return r;
  endfunction

  // Keep the low bytes of a partial word
  function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [3:0] n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (4'(i) < n) begin
        r[8*i +: 8] = w[8*i +: 8];
      end
    end
    return r;
  endfunction

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || out_o.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = out_data_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      mult_q  <= MIX_MULT_RESET;
      shift_q <= MIX_SHIFT_RESET;
      fold_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HASH_SEED:      seed_q  <= cfg_wdata_i;
        CFG_MIX_MULTIPLIER: mult_q  <= cfg_wdata_i;
        CFG_MIX_SHIFT:      shift_q <= cfg_wdata_i[5:0];
        CFG_FOLD_CASE:      fold_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Shared multiplier: phase 0 aL*bL, 1 aL*bH, 2 aH*bL, 3 final add
  assign mul_state = (state_q == ST_LEN_MUL) || (state_q == ST_K1_MUL) ||
                     (state_q == ST_K2_MUL)  || (state_q == ST_ACC_MUL);
  assign mul_done  = mul_state && (ph_q == 2'd3);

  always_comb begin
    mul_a = a_q[31:0];
    mul_b = mult_q[31:0];
    case (ph_q)
      2'd1:    mul_b = mult_q[63:32];
      2'd2:    mul_a = a_q[63:32];
      default: ;
    endcase
    pp_d = {32'b0, mul_a} * {32'b0, mul_b};
  end

  // Partial-product accumulation
  assign prod_full = prod_q + {pp_q[31:0], 32'b0};

  always_comb begin
    prod_d = prod_q;
    ph_d   = ph_q;
    if (mul_state) begin
      ph_d = ph_q + 2'd1;
      case (ph_q)
        2'd1:    prod_d = pp_q;
        2'd2:    prod_d = prod_full;
        default: ;
      endcase
    end
  end

  // Dispatch after the initial accumulator is known
  assign acc_base = (state_q == ST_LEN_MUL) ? (seed_q ^ prod_full) : acc_q;
  assign masked   = keep_bytes(word_q, count_q);
  assign final_val = acc_q ^ (acc_q >> shift_q);

  always_comb begin
    if (count_q == 4'(BLOCK_BYTES)) begin
      disp_state = ST_K1_MUL;
    end else if (count_q != 4'd0) begin
      disp_state = ST_ACC_MUL;
    end else if (last_q) begin
      disp_state = ST_FINAL;
    end else begin
      disp_state = ST_IDLE;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept) state_d = ST_START;
      ST_START:   state_d = first_q ? ST_LEN_MUL : disp_state;
      ST_LEN_MUL: if (mul_done) state_d = disp_state;
      ST_K1_MUL:  if (mul_done) state_d = ST_K2_MUL;
      ST_K2_MUL:  if (mul_done) state_d = ST_ACC_MUL;
      ST_ACC_MUL: if (mul_done) state_d = last_q ? ST_FINAL : ST_IDLE;
      ST_FINAL:   if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath outputs of the sequencer
  always_comb begin
    a_d         = a_q;
    acc_d       = acc_q;
    word_d      = word_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    if (accept) begin
      word_d = fold_q ? lower_word(in_i.data_word) : in_i.data_word;
      if (in_i.byte_count inside {[4'd9:4'd15]}) begin
        count_d = 4'(BLOCK_BYTES);
      end else begin
        count_d = in_i.byte_count;
      end
    end
    case (state_q)
      ST_START: begin
        if (first_q) begin
          a_d = {32'b0, len_q};
        end else begin
          a_d = (disp_state == ST_K1_MUL) ? word_q : (acc_base ^ masked);
        end
      end
      ST_LEN_MUL: begin
        if (mul_done) begin
          acc_d = acc_base;
          a_d   = (disp_state == ST_K1_MUL) ? word_q : (acc_base ^ masked);
        end
      end
      ST_K1_MUL: if (mul_done) a_d = prod_full ^ (prod_full >> shift_q);
      ST_K2_MUL: if (mul_done) a_d = acc_q ^ prod_full;
      ST_ACC_MUL: if (mul_done) acc_d = prod_full;
      ST_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = final_val;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    pp_q       <= pp_d;
    prod_q     <= prod_d;
    word_q     <= word_d;
    count_q    <= count_d;
    out_data_q <= out_data_d;
    if (accept) begin
      first_q <= in_i.first_word;
      last_q  <= in_i.last_word;
      len_q   <= in_i.total_length;
    end
  end

  // Checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == ST_IDLE))
    else $error("ready raised outside idle");

  a_phase_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != 2'd0) |-> mul_state)
    else $error("multiplier phase running outside a multiply state");

  a_final_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) && out_free |=>
      out_valid_q && (out_o.hash_value == $past(final_val)))
    else $error("final hash not loaded into result register");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) && !first_q && (count_q == 4'd0) && !last_q |=>
      (state_q == ST_IDLE))
    else $error("empty middle beat did not return to idle");

endmodule

>>> dv/mm64_hash_checker.sv
// Scoreboard for the murmur64 stream hash: predicts each message hash and checks the output beats.
module mm64_hash_checker
  import mm64_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  mm64_in_if                  in_mon_i,
  mm64_out_if                 out_mon_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_hashes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers and the running accumulator
  logic [63:0] seed_r;
  logic [63:0] mult_r;
  logic [5:0]  shift_r;
  logic        fold_r;
  logic [63:0] acc_r;

  logic [63:0] hash_q[$];
  int unsigned mismatches;

  // ASCII A-Z to a-z, byte by byte
  function automatic logic [63:0] lowercase_ascii(input logic [63:0] word);
    logic [63:0] res;
    logic [7:0]  b;
    int          i;
    res = word;
    for (i = 0; i < BLOCK_BYTES; i++) begin
      b = word[8*i +: 8];
      if (b >= 8'h41 && b <= 8'h5A) res[8*i+5] = 1'b1;
    end
    return res;
  endfunction

  // New accumulator after one message word
  function automatic logic [63:0] absorb_word(input logic [63:0] acc, input logic [63:0] word,
                                              input logic [3:0] count, input logic is_first,
                                              input logic [31:0] len);
    logic [63:0] a;
    logic [63:0] w;
    logic [63:0] k;
    logic [63:0] mask;
    a = is_first ? (seed_r ^ ({32'd0, len} * mult_r)) : acc;
    w = fold_r ? lowercase_ascii(word) : word;
    if (count >= 4'd8) begin
      // full word (counts above 8 clamp here)
      k = w * mult_r;
      k = k ^ (k >> shift_r);
      k = k * mult_r;
      a = (a ^ k) * mult_r;
    end else if (count != 4'd0) begin
      // partial word: clear unused high bytes, no mixing
      mask = {64{1'b1}} >> (8 * (8 - count));
      a = (a ^ (w & mask)) * mult_r;
    end
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] exp_hash;
    if (!rst_ni) begin
      seed_r           = '0;
      mult_r           = MIX_MULT_RESET;
      shift_r          = MIX_SHIFT_RESET;
      fold_r           = 1'b0;
      acc_r            = '0;
      mismatches       = 0;
      hash_q.delete();
      fail_count_o     <= 0;
      pending_hashes_o <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HASH_SEED:      seed_r  = cfg_wdata_i;
          CFG_MIX_MULTIPLIER: mult_r  = cfg_wdata_i;
          CFG_MIX_SHIFT:      shift_r = cfg_wdata_i[5:0];
          CFG_FOLD_CASE:      fold_r  = cfg_wdata_i[0];
          default: ;
        endcase
      end

      // output beat against the oldest expected hash
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (hash_q.size() == 0) begin
          $error("hash_value: expected none, actual %h", out_mon_i.hash_value);
          mismatches++;
        end else begin
          exp_hash = hash_q.pop_front();
          if (out_mon_i.hash_value !== exp_hash) begin
            $error("hash_value: expected %h, actual %h", exp_hash, out_mon_i.hash_value);
            mismatches++;
          end
        end
      end

      // input beat: fold in, queue a hash after the last word
      if (in_mon_i.valid && in_mon_i.ready) begin
        acc_r = absorb_word(acc_r, in_mon_i.data_word, in_mon_i.byte_count,
                            in_mon_i.first_word, in_mon_i.total_length);
        if (in_mon_i.last_word) hash_q.push_back(acc_r ^ (acc_r >> shift_r));
      end

      fail_count_o     <= mismatches;
      pending_hashes_o <= hash_q.size();
    end
  end

endmodule

>>> dv/murmur64_stream_hash_tb.sv
// Testbench top for the murmur64 stream hash: clock, reset, config phases, word stimulus, verdict.
module murmur64_stream_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mm64_pkg::*;

  localparam int unsigned DrainCycles = 24;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         fail_count;
  int unsigned         pending_hashes;
  int unsigned         beats_sent;
  int unsigned         burst_left;

  mm64_in_if  in_ch ();
  mm64_out_if out_ch ();

  murmur64_stream_hash u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  mm64_hash_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_mon_i         (in_ch),
    .out_mon_i        (out_ch),
    .fail_count_o     (fail_count),
    .pending_hashes_o (pending_hashes)
  );

  always #5 clk_i = ~clk_i;

  // Message bytes: either fully random or ASCII around the letter ranges
  function automatic logic [63:0] random_word();
    logic [63:0] w;
    int          i;
    if ($urandom_range(0, 1) == 0) begin
      w = {$urandom, $urandom};
    end else begin
      for (i = 0; i < 8; i++) w[8*i +: 8] = 8'($urandom_range(8'h3F, 8'h7B));
    end
    return w;
  endfunction

  // All four registers back to back, one per cycle
  task automatic write_config(input logic [63:0] seed, input logic [63:0] mult,
                              input logic [5:0] shift, input logic fold);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HASH_SEED;
    cfg_wdata <= seed;
    @(posedge clk_i);
    cfg_index <= CFG_MIX_MULTIPLIER;
    cfg_wdata <= mult;
    @(posedge clk_i);
    // upper bits are don't-care, keep them noisy
    cfg_index <= CFG_MIX_SHIFT;
    cfg_wdata <= {$urandom, 26'($urandom), shift};
    @(posedge clk_i);
    cfg_index <= CFG_FOLD_CASE;
    cfg_wdata <= {$urandom, 31'($urandom), fold};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // One input beat, with bursty gaps in front
  task automatic send_beat(input logic [63:0] word, input logic [3:0] count,
                           input logic is_first, input logic is_last, input logic [31:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.data_word    <= word;
    in_ch.byte_count   <= count;
    in_ch.first_word   <= is_first;
    in_ch.last_word    <= is_last;
    in_ch.total_length <= len;
    @(posedge clk_i iff in_ch.ready);
    beats_sent++;
  endtask

  // Message of msg_len bytes split into words, now and then with a random length field
  task automatic send_message(input int unsigned msg_len);
    int unsigned left;
    logic [3:0]  cnt;
    logic        is_first;
    logic [31:0] len_field;
    left      = msg_len;
    is_first  = 1'b1;
    len_field = ($urandom_range(0, 9) == 0) ? $urandom : msg_len;
    do begin
      cnt = (left >= 8) ? 4'd8 : left[3:0];
      send_beat(random_word(), cnt, is_first, left <= 8, is_first ? len_field : $urandom);
      left     = (left >= 8) ? left - 8 : 0;
      is_first = 1'b0;
    end while (left > 0);
  endtask

  // Mostly messages, some raw beats with arbitrary flags and counts
  task automatic send_random(input int unsigned n_beats);
    int unsigned target;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(random_word(), 4'($urandom), 1'($urandom), 1'($urandom), $urandom);
      end else begin
        send_message(($urandom_range(0, 9) == 0) ? $urandom_range(0, 160)
                                                 : $urandom_range(0, 40));
      end
    end
  endtask

  // Stop traffic, wait for every hash, then for any word still in flight
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_hashes != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Receiver: runs of ready and stall of random length
  initial begin
    int unsigned run;
    logic        level;
    out_ch.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      level = ($urandom_range(0, 9) < 6);
      run   = level ? $urandom_range(1, 40) : $urandom_range(1, 25);
      repeat (run) begin
        out_ch.ready <= level;
        @(posedge clk_i);
      end
    end
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int          ph;
    logic [63:0] mult;
    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_HASH_SEED;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.data_word    <= '0;
    in_ch.byte_count   <= '0;
    in_ch.first_word   <= 1'b0;
    in_ch.last_word    <= 1'b0;
    in_ch.total_length <= '0;
    beats_sent = 0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset configuration
    // words with no first word start from the zero accumulator
    send_beat(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 1'b1, 32'd0);
    // empty message
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1, 32'd0);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 32'd8);
    send_beat(64'h0, 4'd8, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // shortest and longest partial word
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b1, 32'd1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1, 1'b1, 32'd7);
    // oversized counts act as a full word
    send_beat(64'hA5A5_5A5A_0F0F_F0F0, 4'd15, 1'b1, 1'b1, 32'd8);
    send_beat(64'hA5A5_5A5A_0F0F_F0F0, 4'd9, 1'b1, 1'b1, 32'd8);
    // short first word, full middle word, empty last word
    send_beat(64'h1122_3344_5566_7788, 4'd3, 1'b1, 1'b0, 32'd11);
    send_beat(64'h99AA_BBCC_DDEE_FF00, 4'd8, 1'b0, 1'b0, 32'd0);
    send_beat(64'h0, 4'd0, 1'b0, 1'b1, 32'd0);
    // continue after a hash without a new first word
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b1, 32'd0);
    send_beat(64'h8000_0000_0000_0001, 4'd8, 1'b1, 1'b0, 32'd16);
    send_beat(64'h7FFF_FFFF_FFFF_FFFE, 4'd8, 1'b0, 1'b1, 32'd0);
    // empty word between full and partial words
    send_beat(64'hDEAD_BEEF_CAFE_F00D, 4'd8, 1'b1, 1'b0, 32'd13);
    send_beat(64'h0, 4'd0, 1'b0, 1'b0, 32'd0);
    send_beat(64'h0102_0304_0506_0708, 4'd5, 1'b0, 1'b1, 32'd0);
    wait_drained();

    // Extremes: zero seed, all-ones multiplier, widest shift, case folding on
    write_config(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1);
    // letter boundaries: 'A' 'Z' '@' '[' 'a' 'z' '`' '{'
    send_beat(64'h7B60_7A61_5B40_5A41, 4'd8, 1'b1, 1'b1, 32'd8);
    send_beat(64'h7B60_7A61_5B40_5A41, 4'd4, 1'b1, 1'b1, 32'd4);
    send_random(80);
    wait_drained();

    // All-ones seed, zero multiplier, shift of one
    write_config(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 6'd1, 1'b0);
    send_random(60);
    wait_drained();

    // Zero shift wipes the mixed word and the final hash
    write_config({$urandom, $urandom}, MIX_MULT_RESET, 6'd0, 1'b0);
    send_random(40);
    wait_drained();

    // Random settings
    for (ph = 0; ph < 7; ph++) begin
      mult = ($urandom_range(0, 3) == 0) ? MIX_MULT_RESET : {$urandom, $urandom};
      write_config({$urandom, $urandom}, mult, 6'($urandom_range(1, 63)), 1'($urandom));
      send_random(140);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
